[hdl/thp_pkg.sv]
// Teredo header parser package: phase codes, status codes and result type.
// No dependencies; used by thp_core and teredo_header_parser.
package thp_pkg;

    localparam int CntW = 16;

    localparam logic [2:0] PH_TAG_HI = 3'd0;
    localparam logic [2:0] PH_TAG_LO = 3'd1;
    localparam logic [2:0] PH_ORIGIN = 3'd2;
    localparam logic [2:0] PH_AUTH   = 3'd3;
    localparam logic [2:0] PH_IPV6   = 3'd4;
    localparam logic [2:0] PH_HALT   = 3'd5;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_SHORT_TAG    = 3'd1;
    localparam logic [2:0] ST_SHORT_ORIGIN = 3'd2;
    localparam logic [2:0] ST_SHORT_AUTH   = 3'd3;
    localparam logic [2:0] ST_SHORT_IPV6   = 3'd4;
    localparam logic [2:0] ST_DUP_ORIGIN   = 3'd5;
    localparam logic [2:0] ST_AUTH_MISPL   = 3'd6;
    localparam logic [2:0] ST_BAD_TAG      = 3'd7;

    localparam logic [CntW-1:0] MinIpv6Len = 16'd40;
    localparam logic [3:0]      Ipv6Ver    = 4'h6;

    typedef struct packed {
        logic [2:0]      status;
        logic            has_origin;
        logic            has_auth;
        logic [CntW-1:0] inner_offset;
        logic [CntW-1:0] inner_length;
        logic [15:0]     origin_port;
        logic [31:0]     origin_addr;
        logic [7:0]      id_length;
        logic [7:0]      auth_length;
        logic [63:0]     auth_nonce;
        logic [7:0]      confirm_byte;
    } t_result;

endpackage

[hdl/thp_core.sv]
// Teredo header parser core: per-byte parse state and end-of-packet result.
// Depends on thp_pkg.
module thp_core #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    output logic            o_emit,
    output thp_pkg::t_result o_result
);
    import thp_pkg::*;

    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PACKET_BYTES);

    logic [CntW-1:0] r_byte_count, n_byte_count;
    logic [2:0]      r_phase, n_phase;
    logic [CntW-1:0] r_section_start, n_section_start;
    logic [7:0]      r_first_tag, n_first_tag;
    logic [8:0]      r_section_len, n_section_len;
    logic            r_origin_seen, n_origin_seen;
    logic            r_auth_seen, n_auth_seen;
    logic [2:0]      r_error_code, n_error_code;
    logic [15:0]     r_port_hold, n_port_hold;
    logic [31:0]     r_addr_hold, n_addr_hold;
    logic [63:0]     r_nonce_hold, n_nonce_hold;
    logic [15:0]     r_len_hold, n_len_hold;
    logic [7:0]      r_confirm_hold, n_confirm_hold;
    logic [CntW-1:0] r_inner_start, n_inner_start;

    logic            take;
    logic [CntW-1:0] off;
    logic [CntW-1:0] rem;
    logic [CntW-1:0] auth_skip_end;
    logic [CntW-1:0] auth_nonce_end;

    assign take           = i_step && (r_byte_count < MaxCnt);
    assign off            = r_byte_count - r_section_start;
    assign auth_skip_end  = CntW'(r_section_len) + CntW'(4);
    assign auth_nonce_end = CntW'(r_section_len) + CntW'(12);

    always_comb begin
        n_byte_count    = r_byte_count;
        n_phase         = r_phase;
        n_section_start = r_section_start;
        n_first_tag     = r_first_tag;
        n_section_len   = r_section_len;
        n_origin_seen   = r_origin_seen;
        n_auth_seen     = r_auth_seen;
        n_error_code    = r_error_code;
        n_port_hold     = r_port_hold;
        n_addr_hold     = r_addr_hold;
        n_nonce_hold    = r_nonce_hold;
        n_len_hold      = r_len_hold;
        n_confirm_hold  = r_confirm_hold;
        n_inner_start   = r_inner_start;
        if (take) begin
            n_byte_count = r_byte_count + CntW'(1);
            case (r_phase)
                PH_TAG_HI: begin
                    n_section_start = r_byte_count;
                    n_first_tag     = i_data_byte;
                    n_phase         = PH_TAG_LO;
                end
                PH_TAG_LO: begin
                    if (r_first_tag == 8'h00 && i_data_byte == 8'h00) begin
                        if (r_origin_seen) begin
                            n_error_code = ST_DUP_ORIGIN;
                            n_phase      = PH_HALT;
                        end else begin
                            n_phase = PH_ORIGIN;
                        end
                    end else if (r_first_tag == 8'h00 && i_data_byte == 8'h01) begin
                        if (r_origin_seen || r_auth_seen) begin
                            n_error_code = ST_AUTH_MISPL;
                            n_phase      = PH_HALT;
                        end else begin
                            n_phase = PH_AUTH;
                        end
                    end else if (r_first_tag[7:4] == Ipv6Ver) begin
                        n_inner_start = r_section_start;
                        n_phase       = PH_IPV6;
                    end else begin
                        n_error_code = ST_BAD_TAG;
                        n_phase      = PH_HALT;
                    end
                end
                PH_ORIGIN: begin
                    if (off < CntW'(4)) begin
                        n_port_hold = {r_port_hold[7:0], i_data_byte};
                    end else begin
                        n_addr_hold = {r_addr_hold[23:0], i_data_byte};
                        if (off >= CntW'(7)) begin
                            n_origin_seen = 1'b1;
                            n_phase       = PH_TAG_HI;
                        end
                    end
                end
                PH_AUTH: begin
                    if (off == CntW'(2)) begin
                        n_len_hold = {i_data_byte, 8'h00};
                    end else if (off == CntW'(3)) begin
                        n_len_hold    = {r_len_hold[15:8], i_data_byte};
                        n_section_len = {1'b0, r_len_hold[15:8]} + {1'b0, i_data_byte};
                    end else if (off < auth_skip_end) begin
                        n_section_len = r_section_len;
                    end else if (off < auth_nonce_end) begin
                        n_nonce_hold = {r_nonce_hold[55:0], i_data_byte};
                    end else begin
                        n_confirm_hold = i_data_byte;
                        n_auth_seen    = 1'b1;
                        n_phase        = PH_TAG_HI;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    assign rem    = n_byte_count - n_inner_start;
    assign o_emit = i_step && i_last_byte;

    always_comb begin
        o_result = '0;
        case (n_phase)
            PH_TAG_HI, PH_TAG_LO: o_result.status = ST_SHORT_TAG;
            PH_ORIGIN:            o_result.status = ST_SHORT_ORIGIN;
            PH_AUTH:              o_result.status = ST_SHORT_AUTH;
            PH_IPV6: begin
                if (rem >= MinIpv6Len) begin
                    o_result.status       = ST_OK;
                    o_result.inner_offset = n_inner_start;
                    o_result.inner_length = rem;
                end else begin
                    o_result.status = ST_SHORT_IPV6;
                end
            end
            default:              o_result.status = n_error_code;
        endcase
        o_result.has_origin = n_origin_seen;
        o_result.has_auth   = n_auth_seen;
        if (n_origin_seen) begin
            o_result.origin_port = n_port_hold ^ 16'hFFFF;
            o_result.origin_addr = n_addr_hold ^ 32'hFFFF_FFFF;
        end
        if (n_auth_seen) begin
            o_result.id_length    = n_len_hold[15:8];
            o_result.auth_length  = n_len_hold[7:0];
            o_result.auth_nonce   = n_nonce_hold;
            o_result.confirm_byte = n_confirm_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_emit) begin
            r_byte_count  <= '0;
            r_phase       <= PH_TAG_HI;
            r_origin_seen <= 1'b0;
            r_auth_seen   <= 1'b0;
            r_error_code  <= ST_OK;
        end else begin
            r_byte_count  <= n_byte_count;
            r_phase       <= n_phase;
            r_origin_seen <= n_origin_seen;
            r_auth_seen   <= n_auth_seen;
            r_error_code  <= n_error_code;
        end
    end

    always_ff @(posedge i_clk) begin
        r_section_start <= n_section_start;
        r_first_tag     <= n_first_tag;
        r_section_len   <= n_section_len;
        r_port_hold     <= n_port_hold;
        r_addr_hold     <= n_addr_hold;
        r_nonce_hold    <= n_nonce_hold;
        r_len_hold      <= n_len_hold;
        r_confirm_hold  <= n_confirm_hold;
        r_inner_start   <= n_inner_start;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= MaxCnt)
        else $error("byte count beyond packet limit");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_byte_count == '0 && r_phase == PH_TAG_HI && !r_origin_seen))
        else $error("parse state not cleared after packet end");

    a_halt_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |-> r_error_code != ST_OK)
        else $error("halted without error code");

    a_auth_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_auth_seen) |-> !r_origin_seen)
        else $error("authentication accepted after origin indication");

endmodule

[hdl/teredo_header_parser.sv]
// Teredo header parser top level: input register, parse core, result register.
// Depends on thp_pkg and thp_core.
//
// Usage:
//   Input channel: one UDP payload byte per transaction on i_data_byte, with
//   i_last_byte high on the final byte of a packet (i_in_valid / o_in_ready).
//   Output channel: one result transaction per packet, carrying status,
//   presence flags, inner IPv6 offset and length, de-obfuscated origin port
//   and address, and the authentication header fields (o_out_valid /
//   i_out_ready).
//   Result path: the last byte is held in the input register, and its parse
//   update is written into the result register; a full result register can
//   hold that last byte in the input register.
//   Throughput: one byte per cycle while no packet end waits on the result
//   register, set by the single per-byte update of the parse state in thp_core.
//   Reset: parse state and both registers are emptied; no result is pending.
//   Stall: a waiting result is held in the result register; bytes keep
//   flowing until a packet end needs the result register, then the byte
//   in the input register waits and o_in_ready drops.
module teredo_header_parser #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic        o_has_origin,
    output logic        o_has_auth,
    output logic [15:0] o_inner_offset,
    output logic [15:0] o_inner_length,
    output logic [15:0] o_origin_port,
    output logic [31:0] o_origin_addr,
    output logic [7:0]  o_id_length,
    output logic [7:0]  o_auth_length,
    output logic [63:0] o_auth_nonce,
    output logic [7:0]  o_confirm_byte
);
    import thp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_result;

    logic       step;
    logic       step_ok;
    logic       emit;
    t_result    core_result;

    // step only when a possible result has room
    assign step_ok    = !r_in_last || !r_out_valid || i_out_ready;
    assign step       = r_in_valid && step_ok;
    assign o_in_ready = !r_in_valid || step_ok;

    thp_core #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_emit      (emit),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_has_origin   = r_result.has_origin;
    assign o_has_auth     = r_result.has_auth;
    assign o_inner_offset = r_result.inner_offset;
    assign o_inner_length = r_result.inner_length;
    assign o_origin_port  = r_result.origin_port;
    assign o_origin_addr  = r_result.origin_addr;
    assign o_id_length    = r_result.id_length;
    assign o_auth_length  = r_result.auth_length;
    assign o_auth_nonce   = r_result.auth_nonce;
    assign o_confirm_byte = r_result.confirm_byte;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for teredo_header_parser: a directed packet table followed by
// random packets under three handshake idle mixes, checked by a local parser model.
// Depends on thp_pkg and teredo_header_parser.
module tb;
    import thp_pkg::*;

    localparam int         MaxBytes   = 65535;
    localparam int         WatchLimit = 4000;
    localparam int         LongHold   = 600;
    localparam logic [8:0] RandFill   = 9'h100;
    localparam logic [15:0] TagOrigin = 16'h0000;
    localparam logic [15:0] TagAuth   = 16'h0001;

    typedef enum logic [2:0] {
        SEG_NONE, SEG_ORIGIN, SEG_AUTH, SEG_IPV6, SEG_BADTAG, SEG_NOISE
    } seg_e;

    typedef struct packed {
        seg_e        s0;
        seg_e        s1;
        seg_e        s2;
        logic [7:0]  id_len;
        logic [7:0]  auth_len;
        logic [16:0] ip_len;
        logic [7:0]  trim;
        logic [8:0]  fill;
        logic        typed;
        logic [2:0]  st;
    } pkt_case_t;

    localparam int NumCases = 22;
    localparam pkt_case_t DirCases [NumCases] = '{
        '{SEG_ORIGIN, SEG_NONE,   SEG_NONE, 0,   0,   0,     7, 9'h000,   1, ST_SHORT_TAG},
        '{SEG_IPV6,   SEG_NONE,   SEG_NONE, 0,   0,   40,    0, 9'h0FF,   0, ST_OK},
        '{SEG_IPV6,   SEG_NONE,   SEG_NONE, 0,   0,   39,    0, 9'h000,   1, ST_SHORT_IPV6},
        '{SEG_BADTAG, SEG_NONE,   SEG_NONE, 0,   0,   0,     0, 9'h0FF,   1, ST_BAD_TAG},
        '{SEG_BADTAG, SEG_NONE,   SEG_NONE, 0,   0,   0,     0, 9'h000,   1, ST_BAD_TAG},
        '{SEG_BADTAG, SEG_NONE,   SEG_NONE, 0,   0,   0,     0, 9'h060,   1, ST_BAD_TAG},
        '{SEG_ORIGIN, SEG_NONE,   SEG_NONE, 0,   0,   0,     1, RandFill, 1, ST_SHORT_ORIGIN},
        '{SEG_AUTH,   SEG_NONE,   SEG_NONE, 3,   2,   0,     1, RandFill, 1, ST_SHORT_AUTH},
        '{SEG_ORIGIN, SEG_IPV6,   SEG_NONE, 0,   0,   40,    0, 9'h000,   0, ST_OK},
        '{SEG_ORIGIN, SEG_IPV6,   SEG_NONE, 0,   0,   41,    0, 9'h0FF,   0, ST_OK},
        '{SEG_AUTH,   SEG_IPV6,   SEG_NONE, 0,   0,   40,    0, 9'h000,   0, ST_OK},
        '{SEG_AUTH,   SEG_ORIGIN, SEG_IPV6, 255, 5,   40,    0, 9'h0FF,   0, ST_OK},
        '{SEG_AUTH,   SEG_ORIGIN, SEG_IPV6, 5,   9,   60,    0, RandFill, 0, ST_OK},
        '{SEG_ORIGIN, SEG_NONE,   SEG_NONE, 0,   0,   0,     0, RandFill, 0, ST_OK},
        '{SEG_AUTH,   SEG_NONE,   SEG_NONE, 2,   7,   0,     0, RandFill, 0, ST_OK},
        '{SEG_ORIGIN, SEG_ORIGIN, SEG_IPV6, 0,   0,   40,    0, RandFill, 0, ST_OK},
        '{SEG_ORIGIN, SEG_AUTH,   SEG_IPV6, 1,   1,   40,    0, RandFill, 0, ST_OK},
        '{SEG_AUTH,   SEG_AUTH,   SEG_IPV6, 0,   4,   40,    0, RandFill, 0, ST_OK},
        '{SEG_BADTAG, SEG_ORIGIN, SEG_IPV6, 0,   0,   50,    0, RandFill, 1, ST_BAD_TAG},
        '{SEG_IPV6,   SEG_NONE,   SEG_NONE, 0,   0,   60,    0, RandFill, 0, ST_OK},
        '{SEG_IPV6,   SEG_NONE,   SEG_NONE, 0,   0,   1,     0, RandFill, 1, ST_SHORT_TAG},
        '{SEG_NOISE,  SEG_NONE,   SEG_NONE, 0,   0,   20,    0, RandFill, 0, ST_OK}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_status;
    logic        o_has_origin;
    logic        o_has_auth;
    logic [15:0] o_inner_offset;
    logic [15:0] o_inner_length;
    logic [15:0] o_origin_port;
    logic [31:0] o_origin_addr;
    logic [7:0]  o_id_length;
    logic [7:0]  o_auth_length;
    logic [63:0] o_auth_nonce;
    logic [7:0]  o_confirm_byte;

    // parser model state
    logic [15:0] pc_count, pc_start, pc_ipv6_at, pc_port;
    logic [2:0]  pc_phase, pc_err;
    logic [7:0]  pc_tag_hi, pc_id_len, pc_auth_len, pc_confirm;
    logic [8:0]  pc_skip_len;
    logic        pc_origin, pc_auth;
    logic [31:0] pc_addr;
    logic [63:0] pc_nonce;

    t_result    pending_results[$];
    logic [7:0] pkt_bytes[$];

    int   tx_idle      = 31;
    int   rx_idle      = 88;
    int   fail_cnt     = 0;
    int   bytes_sent   = 0;
    int   pkts_sent    = 0;
    int   results_seen = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    logic stall_req    = 1'b0;
    logic stall_done   = 1'b0;

    teredo_header_parser #(.MAX_PACKET_BYTES(MaxBytes)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_data_byte(i_data_byte),
        .i_last_byte(i_last_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_has_origin(o_has_origin),
        .o_has_auth(o_has_auth),
        .o_inner_offset(o_inner_offset),
        .o_inner_length(o_inner_length),
        .o_origin_port(o_origin_port),
        .o_origin_addr(o_origin_addr),
        .o_id_length(o_id_length),
        .o_auth_length(o_auth_length),
        .o_auth_nonce(o_auth_nonce),
        .o_confirm_byte(o_confirm_byte)
    );

    always #5 i_clk = ~i_clk;

    task automatic parser_clear();
        pc_count = '0; pc_start = '0; pc_ipv6_at = '0; pc_port = '0;
        pc_phase = PH_TAG_HI; pc_err = '0; pc_tag_hi = '0; pc_id_len = '0;
        pc_auth_len = '0; pc_confirm = '0; pc_skip_len = '0; pc_origin = 1'b0;
        pc_auth = 1'b0; pc_addr = '0; pc_nonce = '0;
    endtask

    task automatic parse_byte(input logic [7:0] d, input logic lst,
                              output logic done, output t_result res);
        logic [15:0] idx;
        logic [15:0] rel;
        logic [15:0] tag;
        logic [15:0] rem;
        int          off;
        done = 1'b0;
        res  = '0;
        if (int'(pc_count) < MaxBytes) begin
            idx      = pc_count;
            pc_count = idx + 16'd1;
            rel      = idx - pc_start;
            off      = int'(rel);
            case (pc_phase)
                PH_TAG_HI: begin
                    pc_start  = idx;
                    pc_tag_hi = d;
                    pc_phase  = PH_TAG_LO;
                end
                PH_TAG_LO: begin
                    tag = {pc_tag_hi, d};
                    if (tag == TagOrigin) begin
                        if (pc_origin) begin
                            pc_err = ST_DUP_ORIGIN; pc_phase = PH_HALT;
                        end else begin
                            pc_phase = PH_ORIGIN;
                        end
                    end else if (tag == TagAuth) begin
                        if (pc_origin || pc_auth) begin
                            pc_err = ST_AUTH_MISPL; pc_phase = PH_HALT;
                        end else begin
                            pc_phase = PH_AUTH;
                        end
                    end else if (tag[15:12] == Ipv6Ver) begin
                        pc_ipv6_at = pc_start;
                        pc_phase   = PH_IPV6;
                    end else begin
                        pc_err = ST_BAD_TAG; pc_phase = PH_HALT;
                    end
                end
                PH_ORIGIN: begin
                    if (off < 4) begin
                        pc_port = {pc_port[7:0], d};
                    end else begin
                        pc_addr = {pc_addr[23:0], d};
                        if (off >= 7) begin
                            pc_origin = 1'b1;
                            pc_phase  = PH_TAG_HI;
                        end
                    end
                end
                PH_AUTH: begin
                    if (off == 2) begin
                        pc_id_len   = d;
                        pc_auth_len = 8'h00;
                    end else if (off == 3) begin
                        pc_auth_len = d;
                        pc_skip_len = {1'b0, pc_id_len} + {1'b0, d};
                    end else if (off < 4 + int'(pc_skip_len)) begin
                        // id and authenticator strings are skipped
                    end else if (off < 12 + int'(pc_skip_len)) begin
                        pc_nonce = {pc_nonce[55:0], d};
                    end else begin
                        pc_confirm = d;
                        pc_auth    = 1'b1;
                        pc_phase   = PH_TAG_HI;
                    end
                end
                default: ;
            endcase
        end
        if (lst) begin
            done = 1'b1;
            case (pc_phase)
                PH_TAG_HI, PH_TAG_LO: res.status = ST_SHORT_TAG;
                PH_ORIGIN:            res.status = ST_SHORT_ORIGIN;
                PH_AUTH:              res.status = ST_SHORT_AUTH;
                PH_IPV6: begin
                    rem = pc_count - pc_ipv6_at;
                    if (rem >= MinIpv6Len) begin
                        res.status       = ST_OK;
                        res.inner_offset = pc_ipv6_at;
                        res.inner_length = rem;
                    end else begin
                        res.status = ST_SHORT_IPV6;
                    end
                end
                default:              res.status = pc_err;
            endcase
            res.has_origin = pc_origin;
            res.has_auth   = pc_auth;
            if (pc_origin) begin
                res.origin_port = pc_port ^ 16'hFFFF;
                res.origin_addr = pc_addr ^ 32'hFFFF_FFFF;
            end
            if (pc_auth) begin
                res.id_length    = pc_id_len;
                res.auth_length  = pc_auth_len;
                res.auth_nonce   = pc_nonce;
                res.confirm_byte = pc_confirm;
            end
            parser_clear();
        end
    endtask

    function automatic logic [7:0] fill_byte(input logic [8:0] fill);
        return fill[8] ? 8'($urandom) : fill[7:0];
    endfunction

    task automatic build_packet(input pkt_case_t c);
        seg_e        segs [3];
        logic [15:0] tag;
        int          n;
        segs[0] = c.s0;
        segs[1] = c.s1;
        segs[2] = c.s2;
        pkt_bytes.delete();
        foreach (segs[k]) begin
            case (segs[k])
                SEG_ORIGIN: begin
                    pkt_bytes.push_back(TagOrigin[15:8]);
                    pkt_bytes.push_back(TagOrigin[7:0]);
                    repeat (6) pkt_bytes.push_back(fill_byte(c.fill));
                end
                SEG_AUTH: begin
                    pkt_bytes.push_back(TagAuth[15:8]);
                    pkt_bytes.push_back(TagAuth[7:0]);
                    pkt_bytes.push_back(c.id_len);
                    pkt_bytes.push_back(c.auth_len);
                    repeat (int'(c.id_len) + int'(c.auth_len) + 9)
                        pkt_bytes.push_back(fill_byte(c.fill));
                end
                SEG_IPV6: begin
                    tag[7:0] = fill_byte(c.fill);
                    pkt_bytes.push_back({Ipv6Ver, tag[3:0]});
                    repeat (int'(c.ip_len) - 1) pkt_bytes.push_back(fill_byte(c.fill));
                end
                SEG_BADTAG: begin
                    tag = {fill_byte(c.fill), fill_byte(c.fill)};
                    if (tag[15:12] == Ipv6Ver) tag[12] = ~tag[12];
                    if (tag == TagOrigin || tag == TagAuth) tag = TagAuth + 16'd1;
                    pkt_bytes.push_back(tag[15:8]);
                    pkt_bytes.push_back(tag[7:0]);
                end
                SEG_NOISE: repeat (int'(c.ip_len)) pkt_bytes.push_back(8'($urandom));
                default: ;
            endcase
        end
        n = int'(c.trim);
        while (n > 0 && pkt_bytes.size() > 1) begin
            void'(pkt_bytes.pop_back());
            n--;
        end
        if (pkt_bytes.size() == 0) pkt_bytes.push_back(fill_byte(c.fill));
    endtask

    task automatic send_packet(input logic typed, input logic [2:0] st);
        t_result res;
        logic    done;
        logic    lst;
        foreach (pkt_bytes[k]) begin
            lst = (k == pkt_bytes.size() - 1);
            while ($urandom_range(99) < tx_idle) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_data_byte <= pkt_bytes[k];
            i_last_byte <= lst;
            do @(posedge i_clk); while (!o_in_ready);
            bytes_sent++;
            parse_byte(pkt_bytes[k], lst, done, res);
            if (done) begin
                if (typed) begin
                    res        = '0;
                    res.status = st;
                end
                pending_results.push_back(res);
            end
        end
        pkts_sent++;
    endtask

    task automatic random_packet();
        pkt_case_t c;
        seg_e      segs [3];
        int        r;
        int        n;
        c      = '0;
        c.fill = RandFill;
        if ($urandom_range(19) == 0) c.fill = $urandom_range(1) ? 9'h0FF : 9'h000;
        c.id_len   = ($urandom_range(9) < 8) ? 8'($urandom_range(6)) : 8'($urandom);
        c.auth_len = ($urandom_range(9) < 8) ? 8'($urandom_range(6)) : 8'($urandom);
        r = $urandom_range(99);
        if (r < 70)      c.ip_len = 17'($urandom_range(40, 60));
        else if (r < 85) c.ip_len = 17'($urandom_range(1, 39));
        else             c.ip_len = 17'($urandom_range(61, 300));
        r = $urandom_range(99);
        if (r < 75) begin
            segs = '{SEG_NONE, SEG_NONE, SEG_NONE};
            n    = 0;
            if ($urandom_range(1) == 1) begin
                segs[n] = SEG_AUTH;
                n++;
            end
            if ($urandom_range(9) < 6) begin
                segs[n] = SEG_ORIGIN;
                n++;
            end
            segs[n] = SEG_IPV6;
            c.s0    = segs[0];
            c.s1    = segs[1];
            c.s2    = segs[2];
            c.trim  = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 20)) : 8'd0;
        end else if (r < 90) begin
            c.s0   = seg_e'($urandom_range(1, 4));
            c.s1   = seg_e'($urandom_range(1, 4));
            c.s2   = seg_e'($urandom_range(0, 4));
            c.trim = 8'($urandom_range(0, 12));
        end else begin
            c.s0     = SEG_NOISE;
            c.ip_len = 17'($urandom_range(1, 24));
        end
        build_packet(c);
        send_packet(1'b0, ST_OK);
    endtask

    task automatic run_random(input int min_bytes, input int min_pkts);
        int b0;
        int p0;
        b0 = bytes_sent;
        p0 = pkts_sent;
        while (bytes_sent - b0 < min_bytes || pkts_sent - p0 < min_pkts) random_packet();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic cmp_field(input string fld, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fld, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_side
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got status %0d",
                         $time, o_status);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("status", 64'(want.status), 64'(o_status));
                cmp_field("has_origin", 64'(want.has_origin), 64'(o_has_origin));
                cmp_field("has_auth", 64'(want.has_auth), 64'(o_has_auth));
                cmp_field("inner_offset", 64'(want.inner_offset), 64'(o_inner_offset));
                cmp_field("inner_length", 64'(want.inner_length), 64'(o_inner_length));
                cmp_field("origin_port", 64'(want.origin_port), 64'(o_origin_port));
                cmp_field("origin_addr", 64'(want.origin_addr), 64'(o_origin_addr));
                cmp_field("id_length", 64'(want.id_length), 64'(o_id_length));
                cmp_field("auth_length", 64'(want.auth_length), 64'(o_auth_length));
                cmp_field("auth_nonce", want.auth_nonce, o_auth_nonce);
                cmp_field("confirm_byte", 64'(want.confirm_byte), 64'(o_confirm_byte));
            end
        end
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_req && !stall_done) begin
            hold_left   <= LongHold;
            stall_done  <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WatchLimit) begin
            $display("%0t ns: no transaction for %0d cycles", $time, WatchLimit);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        parser_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NumCases; k++) begin
            build_packet(DirCases[k]);
            send_packet(DirCases[k].typed, DirCases[k].st);
        end
        run_random(100, 3);
        drain();

        tx_idle = 88;
        rx_idle <= 31;
        run_random(100, 3);
        drain();

        // no idling; receiver holds off for a long stretch at the start
        tx_idle = 0;
        rx_idle <= 0;
        stall_req <= 1'b1;
        run_random(100, 3);
        drain();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d packets / %0d bytes: header table, long auth header, bad orders,",
                 pkts_sent, bytes_sent);
        $display("noise, three idle mixes and a long output stall; %0d results checked",
                 results_seen);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
